FILE: rtl/tpsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpsd_pkg
// Shared types and constants of the TGA pixel stream decoder.
// ----------------------------------------------------------------------------
package tpsd_pkg;

    localparam int          CFG_IDX_W   = 2;
    localparam int          CFG_DATA_W  = 32;
    localparam int          QUEUE_DEPTH = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_KIND  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HAS_ALPHA   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_COUNT = 2'd2;

    localparam logic [7:0]  HDR_REPEAT_MIN = 8'd128;
    localparam logic [7:0]  HDR_REPEAT_OFS = 8'd127;
    localparam logic [7:0]  ALPHA_OPAQUE   = 8'd255;

    // one finished pixel request handed from front to back
    typedef struct packed {
        logic       gray;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic [7:0] alpha;
        logic [7:0] len;
        logic [7:0] rem_low;
        logic       last;
    } t_pix_rec;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

FILE: rtl/tpsd_byte_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpsd_byte_if
// Byte stream channel: valid/ready with one data byte.
// ----------------------------------------------------------------------------
interface tpsd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

FILE: rtl/tpsd_pix_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpsd_pix_if
// Pixel run channel: valid/ready with RGBA color, repeat count and end flag.
// ----------------------------------------------------------------------------
interface tpsd_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [7:0] repeat_count;
    logic       image_end;

    modport source (output valid, output red, output green, output blue, output alpha,
                    output repeat_count, output image_end, input ready);
    modport sink   (input valid, input red, input green, input blue, input alpha,
                    input repeat_count, input image_end, output ready);
endinterface

FILE: rtl/tpsd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpsd_front
// Byte classifier: config registers, packet headers, pixel assembly and
// image position tracking. Pushes one request per finished pixel.
// ----------------------------------------------------------------------------
module tpsd_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    tpsd_byte_if.sink                      i_in,
    input  logic                           i_cfg_we,
    input  logic [tpsd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [tpsd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  tpsd_pkg::t_q_stat              i_q_stat,
    output logic                           o_push,
    output tpsd_pkg::t_pix_rec             o_rec
);
    import tpsd_pkg::*;

    localparam logic [1:0] PH_BLUE  = 2'd0;
    localparam logic [1:0] PH_GREEN = 2'd1;
    localparam logic [1:0] PH_RED   = 2'd2;
    localparam logic [1:0] PH_ALPHA = 2'd3;

    logic [1:0]  r_kind, n_kind;
    logic        r_has_alpha, n_has_alpha;
    logic [31:0] r_pixel_count, n_pixel_count;
    logic [1:0]  r_phase, n_phase;
    logic        r_hdr, n_hdr;
    logic [7:0]  r_raw_rem, n_raw_rem;
    logic        r_rep, n_rep;
    logic [7:0]  r_rep_len, n_rep_len;
    logic [7:0]  r_blue, n_blue;
    logic [7:0]  r_green, n_green;
    logic [7:0]  r_red, n_red;
    logic [31:0] r_remaining, n_remaining;

    logic        accept;
    logic        rle;
    logic        gray;
    logic        pix;
    logic        last;
    logic        restart;
    logic        cfg_hit;
    logic [7:0]  b;
    logic [7:0]  alpha;
    logic [7:0]  len;
    logic [7:0]  raw_dec;

    assign i_in.ready = !i_q_stat.full;
    assign accept     = i_in.valid && !i_q_stat.full;
    assign b          = i_in.in_byte;
    assign rle        = r_kind[1];
    assign gray       = r_kind[0];
    assign raw_dec    = r_raw_rem - 8'd1;
    assign len        = (rle && r_rep) ? r_rep_len : 8'd1;
    assign last       = {24'd0, len} >= r_remaining;

    always_comb begin
        n_kind        = r_kind;
        n_has_alpha   = r_has_alpha;
        n_pixel_count = r_pixel_count;
        n_phase       = r_phase;
        n_hdr         = r_hdr;
        n_raw_rem     = r_raw_rem;
        n_rep         = r_rep;
        n_rep_len     = r_rep_len;
        n_blue        = r_blue;
        n_green       = r_green;
        n_red         = r_red;
        n_remaining   = r_remaining;
        pix           = 1'b0;
        alpha         = ALPHA_OPAQUE;
        cfg_hit       = 1'b0;

        if (accept && r_pixel_count != 32'd0) begin
            if (rle && r_hdr) begin
                if (b < HDR_REPEAT_MIN) begin
                    n_rep     = 1'b0;
                    n_raw_rem = b + 8'd1;
                end else begin
                    n_rep     = 1'b1;
                    n_rep_len = b - HDR_REPEAT_OFS;
                end
                n_hdr   = 1'b0;
                n_phase = PH_BLUE;
            end else if (gray) begin
                pix     = 1'b1;
                n_phase = PH_BLUE;
            end else begin
                unique case (r_phase)
                    PH_BLUE: begin
                        n_blue  = b;
                        n_phase = PH_GREEN;
                    end
                    PH_GREEN: begin
                        n_green = b;
                        n_phase = PH_RED;
                    end
                    PH_RED: begin
                        n_red = b;
                        if (r_has_alpha) begin
                            n_phase = PH_ALPHA;
                        end else begin
                            pix     = 1'b1;
                            n_phase = PH_BLUE;
                        end
                    end
                    PH_ALPHA: begin
                        alpha   = b;
                        pix     = 1'b1;
                        n_phase = PH_BLUE;
                    end
                endcase
            end

            if (pix) begin
                if (rle) begin
                    if (r_rep) begin
                        n_hdr = 1'b1;
                    end else begin
                        n_raw_rem = raw_dec;
                        if (raw_dec == 8'd0) begin
                            n_hdr = 1'b1;
                        end
                    end
                end
                n_remaining = r_remaining - {24'd0, len};
            end
        end

        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_IMAGE_KIND: begin
                    n_kind  = i_cfg_data[1:0];
                    cfg_hit = 1'b1;
                end
                CFG_HAS_ALPHA: begin
                    n_has_alpha = i_cfg_data[0];
                    cfg_hit     = 1'b1;
                end
                CFG_PIXEL_COUNT: begin
                    n_pixel_count = i_cfg_data;
                    cfg_hit       = 1'b1;
                end
                default: cfg_hit = 1'b0;
            endcase
        end

        restart = (pix && last) || cfg_hit;
        if (restart) begin
            n_phase     = PH_BLUE;
            n_hdr       = 1'b1;
            n_raw_rem   = 8'd0;
            n_rep       = 1'b0;
            n_rep_len   = 8'd0;
            n_remaining = n_pixel_count;
        end
    end

    assign o_push          = pix;
    assign o_rec.gray      = gray;
    assign o_rec.blue      = gray ? b : r_blue;
    assign o_rec.green     = r_green;
    assign o_rec.red       = n_red;
    assign o_rec.alpha     = alpha;
    assign o_rec.len       = len;
    assign o_rec.rem_low   = r_remaining[7:0];
    assign o_rec.last      = last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind        <= 2'd0;
            r_has_alpha   <= 1'b0;
            r_pixel_count <= 32'd0;
            r_phase       <= PH_BLUE;
            r_hdr         <= 1'b1;
            r_raw_rem     <= 8'd0;
            r_rep         <= 1'b0;
            r_rep_len     <= 8'd0;
            r_blue        <= 8'd0;
            r_green       <= 8'd0;
            r_red         <= 8'd0;
            r_remaining   <= 32'd0;
        end else begin
            r_kind        <= n_kind;
            r_has_alpha   <= n_has_alpha;
            r_pixel_count <= n_pixel_count;
            r_phase       <= n_phase;
            r_hdr         <= n_hdr;
            r_raw_rem     <= n_raw_rem;
            r_rep         <= n_rep;
            r_rep_len     <= n_rep_len;
            r_blue        <= n_blue;
            r_green       <= n_green;
            r_red         <= n_red;
            r_remaining   <= n_remaining;
        end
    end

endmodule

FILE: rtl/tpsd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpsd_queue
// Small FIFO of pixel requests between front and back.
// ----------------------------------------------------------------------------
module tpsd_queue #(
    parameter int DEPTH = tpsd_pkg::QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  tpsd_pkg::t_pix_rec  i_rec,
    input  logic                i_pop,
    output tpsd_pkg::t_pix_rec  o_rec,
    output tpsd_pkg::t_q_stat   o_stat
);
    import tpsd_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    t_pix_rec         r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_stat.full  = r_count == CNT_W'(DEPTH);
    assign o_stat.empty = r_count == '0;
    assign o_rec        = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == PTR_LAST) ? '0 : r_wr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_LAST) ? '0 : r_rd + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

endmodule

FILE: rtl/tpsd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpsd_back
// Pixel formatter: gray expansion, run clipping and the output register.
// ----------------------------------------------------------------------------
module tpsd_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tpsd_pkg::t_q_stat  i_q_stat,
    input  tpsd_pkg::t_pix_rec i_rec,
    output logic               o_pop,
    tpsd_pix_if.source         o_pix
);
    import tpsd_pkg::*;

    logic       r_valid;
    logic [7:0] r_red;
    logic [7:0] r_green;
    logic [7:0] r_blue;
    logic [7:0] r_alpha;
    logic [7:0] r_count;
    logic       r_end;

    assign o_pop = !i_q_stat.empty && (!r_valid || o_pix.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (o_pix.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_red   <= i_rec.gray ? i_rec.blue : i_rec.red;
            r_green <= i_rec.gray ? i_rec.blue : i_rec.green;
            r_blue  <= i_rec.blue;
            r_alpha <= i_rec.alpha;
            // final run is cut to the pixels left
            r_count <= i_rec.last ? i_rec.rem_low : i_rec.len;
            r_end   <= i_rec.last;
        end
    end

    assign o_pix.valid        = r_valid;
    assign o_pix.red          = r_red;
    assign o_pix.green        = r_green;
    assign o_pix.blue         = r_blue;
    assign o_pix.alpha        = r_alpha;
    assign o_pix.repeat_count = r_count;
    assign o_pix.image_end    = r_end;

endmodule

FILE: rtl/tga_pixel_stream_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tga_pixel_stream_decoder
// TGA pixel data decoder: bytes in, RGBA pixel runs out.
// ----------------------------------------------------------------------------
// Takes one byte of TGA pixel data per clock while the request queue has
// room and returns one RGBA run per finished pixel, with its repeat count
// and an end-of-image flag. The front handles each byte in the cycle it is
// accepted; a finished pixel goes into the request queue and from there into
// the output register. The queue (QUEUE_DEPTH entries) lets bytes keep
// flowing while the output waits, so a byte is accepted every cycle as long
// as the consumer keeps up. Configure image_kind, has_alpha and pixel_count
// while the stream is idle; writing any of them restarts the image position.
module tga_pixel_stream_decoder #(
    parameter int QUEUE_DEPTH = tpsd_pkg::QUEUE_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    tpsd_byte_if.sink                       i_in,
    tpsd_pix_if.source                      o_pix,
    input  logic                            i_cfg_we,
    input  logic [tpsd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [tpsd_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import tpsd_pkg::*;

    logic     push;
    logic     pop;
    t_pix_rec front_rec;
    t_pix_rec queue_rec;
    t_q_stat  q_stat;

    tpsd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_q_stat   (q_stat),
        .o_push     (push),
        .o_rec      (front_rec)
    );

    tpsd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (front_rec),
        .i_pop   (pop),
        .o_rec   (queue_rec),
        .o_stat  (q_stat)
    );

    tpsd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_stat (q_stat),
        .i_rec    (queue_rec),
        .o_pop    (pop),
        .o_pix    (o_pix)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_stat.full)
        else $error("pixel request pushed into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_stat.empty)
        else $error("pixel request popped from empty queue");

    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pix.valid |-> o_pix.repeat_count != 8'd0)
        else $error("pixel run with zero repeat count");

    a_pop_loads_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |=> o_pix.valid)
        else $error("popped request did not reach the output");

endmodule
